### rtl/fvsc_pkg.sv
// Shared types, constants and the sine table generator for the stereo chorus.
// No dependencies; every other file but fvsc_ram refers to this package by scoped names.
package fvsc_pkg;

    localparam int NUM_VOICES = 4;
    localparam int VOICE_W    = 2;
    localparam int SAMPLE_W   = 24;
    localparam int SINE_W     = 16;
    localparam int PHASE_W    = 32;
    localparam int BASE_W     = 12;
    localparam int STEP_W     = 24;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FRAC_W     = 8;

    // modulation depth in Q24, delay in Q8
    localparam int M_W        = 21;
    localparam int D8_W       = 21;
    localparam int PROD_M_W   = 37;
    localparam logic [M_W-1:0] M_LOW  = 21'd16777;
    localparam logic [M_W-1:0] M_SPAN = 21'd1660944;

    // datapath widths after interpolation, weighting and summing
    localparam int MIX_W  = 33;
    localparam int WGT_W  = 16;
    localparam int PROD_W = 50;
    localparam int ACC_W  = 52;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    localparam logic [BASE_W-1:0] BASE_RESET [NUM_VOICES] =
        '{12'd1132, 12'd1440, 12'd1728, 12'd1344};
    localparam logic [STEP_W-1:0] STEP_RESET [NUM_VOICES] =
        '{24'd58161, 24'd51003, 24'd42950, 24'd39370};
    localparam logic [WGT_W-1:0] VOICE_WEIGHT [NUM_VOICES] =
        '{16'd32768, 16'd32768, 16'd22938, 16'd18678};

    localparam logic [VOICE_W-1:0] LAST_VOICE = 2'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BASE_ONE   = 3'd0,
        REG_BASE_TWO   = 3'd1,
        REG_BASE_THREE = 3'd2,
        REG_BASE_FOUR  = 3'd3,
        REG_STEP_ONE   = 3'd4,
        REG_STEP_TWO   = 3'd5,
        REG_STEP_THREE = 3'd6,
        REG_STEP_FOUR  = 3'd7
    } t_cfg_index;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SINE,
        F_MOD,
        F_DLY,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ADDR_B,
        B_MIX,
        B_WEIGHT,
        B_ACC
    } t_back_state;

    // one ring tap request, less its address
    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic               valid_a;
        logic               valid_b;
        logic [FRAC_W-1:0]  frac;
    } t_tap_ctl;

    // Quarter-wave odd polynomial in Q30; evaluated at elaboration only.
    function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k,
                                                          input int unsigned bits);
        longint unsigned t, quad, r, x, x2, p, s, mag;
        logic signed [SINE_W-1:0] res;
        t    = (longint'(k) << (32 - bits)) & 64'hFFFF_FFFF;
        quad = t >> 30;
        r    = t & 64'h3FFF_FFFF;
        if (quad[0]) r = 64'd1073741824 - r;
        x    = (r * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        p    = 64'd1073741824 - x2 / 72;
        p    = 64'd1073741824 - ((x2 * p) >> 30) / 42;
        p    = 64'd1073741824 - ((x2 * p) >> 30) / 20;
        p    = 64'd1073741824 - ((x2 * p) >> 30) / 6;
        s    = (x * p) >> 30;
        mag  = (s * 64'd32767 + 64'd536870912) >> 30;
        if (mag > 64'd32767) mag = 64'd32767;
        res  = SINE_W'(mag);
        if (quad >= 2) res = -res;
        return res;
    endfunction

endpackage

### rtl/four_voice_stereo_chorus_unit.sv
// Top level of the four-voice stereo chorus: front end, tap queue, back end
// and the two delay rings. Depends on fvsc_pkg and fvsc_front/queue/ram/back.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-------------------------
//   in      | into unit | i_in_valid / o_in_stall   | i_left_in, i_right_in
//   out     | from unit | o_out_valid / i_out_stall | o_left_out, o_right_out
//   cfg     | into unit | i_cfg_we                  | i_cfg_addr, i_cfg_wdata
//
// The next request is taken in the cycle that an item's result appears. The
// front steps through four states per voice (sine lookup, depth multiply,
// delay multiply, tap push) and the back through five per tap (pop, second
// address, interpolate, weight, accumulate) on the single read port of each
// ring, so the back sets the pace.
// Reset is synchronous, active low; the rings need no clearing pass since a
// fill mark makes unwritten entries read as zero.
// The out register holds a finished result while the front takes the next
// request; the back waits only when that register is still stalled.
module four_voice_stereo_chorus_unit #(
    parameter int RING_DEPTH   = 4096,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fvsc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [fvsc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_right_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fvsc_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [fvsc_pkg::SAMPLE_W-1:0] o_right_out
);

    localparam int RING_BITS = $clog2(RING_DEPTH);
    localparam int CTL_W     = $bits(fvsc_pkg::t_tap_ctl);
    localparam int TAP_W     = CTL_W + RING_BITS;

    // tap request path
    logic                 w_push, w_pop, w_q_full, w_q_empty, w_back_busy;
    fvsc_pkg::t_tap_ctl   w_push_ctl;
    logic [RING_BITS-1:0] w_push_addr;
    logic [TAP_W-1:0]     w_head;

    // ring ports
    logic                          w_ring_we;
    logic [RING_BITS-1:0]          w_waddr, w_raddr;
    logic [fvsc_pkg::SAMPLE_W-1:0] w_left_wdata, w_right_wdata;
    logic [fvsc_pkg::SAMPLE_W-1:0] w_left_rdata, w_right_rdata;

    fvsc_front #(
        .RING_DEPTH  (RING_DEPTH),
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_left_in    (i_left_in),
        .i_right_in   (i_right_in),
        .i_back_busy  (w_back_busy),
        .i_queue_empty(w_q_empty),
        .i_queue_full (w_q_full),
        .o_push       (w_push),
        .o_tap_ctl    (w_push_ctl),
        .o_tap_addr   (w_push_addr),
        .o_ring_we    (w_ring_we),
        .o_ring_waddr (w_waddr),
        .o_left_wdata (w_left_wdata),
        .o_right_wdata(w_right_wdata)
    );

    // hold up to one item's worth of tap requests
    fvsc_queue #(
        .WIDTH(TAP_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_push_ctl, w_push_addr}),
        .o_full (w_q_full),
        .i_pop  (w_pop),
        .o_data (w_head),
        .o_empty(w_q_empty)
    );

    fvsc_ram #(
        .WIDTH(fvsc_pkg::SAMPLE_W),
        .DEPTH(RING_DEPTH)
    ) u_left_ring (
        .i_clk  (i_clk),
        .i_we   (w_ring_we),
        .i_waddr(w_waddr),
        .i_wdata(w_left_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_left_rdata)
    );

    fvsc_ram #(
        .WIDTH(fvsc_pkg::SAMPLE_W),
        .DEPTH(RING_DEPTH)
    ) u_right_ring (
        .i_clk  (i_clk),
        .i_we   (w_ring_we),
        .i_waddr(w_waddr),
        .i_wdata(w_right_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_right_rdata)
    );

    fvsc_back #(
        .RING_DEPTH(RING_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue_empty(w_q_empty),
        .i_tap_ctl    (fvsc_pkg::t_tap_ctl'(w_head[TAP_W-1 -: CTL_W])),
        .i_tap_addr   (w_head[RING_BITS-1:0]),
        .o_pop        (w_pop),
        .o_ring_raddr (w_raddr),
        .i_left_rdata (w_left_rdata),
        .i_right_rdata(w_right_rdata),
        .o_busy       (w_back_busy),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out)
    );

endmodule

### rtl/fvsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fvsc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fvsc_queue.sv
// Small show-ahead queue of tap requests between front and back.
// Depends on fvsc_pkg for depth constants.
module fvsc_queue #(
    parameter int WIDTH = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_slot [fvsc_pkg::QUEUE_DEPTH];
    logic [fvsc_pkg::QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [fvsc_pkg::QUEUE_PTR_W:0]   r_count;

    assign o_full  = (r_count == (fvsc_pkg::QUEUE_PTR_W + 1)'(fvsc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= r_wr + 1'b1;
            if (i_pop && !o_empty) r_rd <= r_rd + 1'b1;
            unique case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/fvsc_front.sv
// Front end: accepts samples, writes the rings, runs the LFOs and turns each
// voice into a ring tap request. Depends on fvsc_pkg.
module fvsc_front #(
    parameter int RING_DEPTH   = 4096,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fvsc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [fvsc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_right_in,
    input  logic                                i_back_busy,
    input  logic                                i_queue_empty,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output fvsc_pkg::t_tap_ctl                  o_tap_ctl,
    output logic [$clog2(RING_DEPTH)-1:0]       o_tap_addr,
    output logic                                o_ring_we,
    output logic [$clog2(RING_DEPTH)-1:0]       o_ring_waddr,
    output logic [fvsc_pkg::SAMPLE_W-1:0]       o_left_wdata,
    output logic [fvsc_pkg::SAMPLE_W-1:0]       o_right_wdata
);

    localparam int RING_BITS = $clog2(RING_DEPTH);
    localparam int SINE_BITS = $clog2(SINE_ENTRIES);
    localparam int POS_W     = RING_BITS + fvsc_pkg::FRAC_W;

    fvsc_pkg::t_front_state r_state, n_state;

    logic [fvsc_pkg::BASE_W-1:0]  r_base  [fvsc_pkg::NUM_VOICES];
    logic [fvsc_pkg::STEP_W-1:0]  r_step  [fvsc_pkg::NUM_VOICES];
    logic [fvsc_pkg::PHASE_W-1:0] r_phase [fvsc_pkg::NUM_VOICES];
    logic [RING_BITS-1:0]         r_wp, r_cur_w;
    logic                         r_wrapped;
    logic [fvsc_pkg::VOICE_W-1:0] r_voice;
    logic signed [fvsc_pkg::SINE_W-1:0] r_sine;
    logic [fvsc_pkg::M_W-1:0]     r_m;
    logic [fvsc_pkg::D8_W-1:0]    r_d8;

    logic signed [fvsc_pkg::SINE_W-1:0] w_sine [SINE_ENTRIES];
    logic                          w_ready, w_accept;
    logic [fvsc_pkg::SINE_W-1:0]   w_sine_u;
    logic [fvsc_pkg::PROD_M_W-1:0] w_mod_prod, w_dly_prod;
    logic [POS_W-1:0]              w_pos;
    logic [RING_BITS-1:0]          w_a, w_b;

    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sine
        assign w_sine[k] = fvsc_pkg::sine_entry(k, SINE_BITS);
    end

    // datapath for the current voice
    assign w_sine_u   = {~r_sine[fvsc_pkg::SINE_W-1], r_sine[fvsc_pkg::SINE_W-2:0]};
    assign w_mod_prod = fvsc_pkg::PROD_M_W'(fvsc_pkg::M_SPAN)
                        * fvsc_pkg::PROD_M_W'(w_sine_u);
    assign w_dly_prod = fvsc_pkg::PROD_M_W'(r_base[r_voice])
                        * fvsc_pkg::PROD_M_W'({1'b1, 24'd0} + 25'(r_m));
    assign w_pos      = {r_cur_w, {fvsc_pkg::FRAC_W{1'b0}}} - POS_W'(r_d8);
    assign w_a        = w_pos[POS_W-1:fvsc_pkg::FRAC_W];
    assign w_b        = w_a + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fvsc_pkg::F_IDLE: if (w_accept) n_state = fvsc_pkg::F_SINE;
            fvsc_pkg::F_SINE: n_state = fvsc_pkg::F_MOD;
            fvsc_pkg::F_MOD:  n_state = fvsc_pkg::F_DLY;
            fvsc_pkg::F_DLY:  n_state = fvsc_pkg::F_PUSH;
            fvsc_pkg::F_PUSH: begin
                if (!i_queue_full) begin
                    n_state = (r_voice == fvsc_pkg::LAST_VOICE) ? fvsc_pkg::F_IDLE
                                                                : fvsc_pkg::F_SINE;
                end
            end
            default: n_state = fvsc_pkg::F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        w_ready           = i_rst_n && (r_state == fvsc_pkg::F_IDLE)
                            && i_queue_empty && !i_back_busy;
        w_accept          = w_ready && i_in_valid;
        o_in_stall        = !w_ready;
        o_ring_we         = w_accept;
        o_ring_waddr      = r_wp;
        o_left_wdata      = i_left_in;
        o_right_wdata     = i_right_in;
        o_push            = (r_state == fvsc_pkg::F_PUSH) && !i_queue_full;
        o_tap_addr        = w_a;
        o_tap_ctl.voice   = r_voice;
        o_tap_ctl.valid_a = r_wrapped || (w_a <= r_cur_w);
        o_tap_ctl.valid_b = r_wrapped || (w_b <= r_cur_w);
        o_tap_ctl.frac    = w_pos[fvsc_pkg::FRAC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fvsc_pkg::F_IDLE;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_voice   <= '0;
            for (int v = 0; v < fvsc_pkg::NUM_VOICES; v++) begin
                r_phase[v] <= '0;
                r_base[v]  <= fvsc_pkg::BASE_RESET[v];
                r_step[v]  <= fvsc_pkg::STEP_RESET[v];
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (fvsc_pkg::t_cfg_index'(i_cfg_addr))
                    fvsc_pkg::REG_BASE_ONE:   r_base[0] <= i_cfg_wdata[fvsc_pkg::BASE_W-1:0];
                    fvsc_pkg::REG_BASE_TWO:   r_base[1] <= i_cfg_wdata[fvsc_pkg::BASE_W-1:0];
                    fvsc_pkg::REG_BASE_THREE: r_base[2] <= i_cfg_wdata[fvsc_pkg::BASE_W-1:0];
                    fvsc_pkg::REG_BASE_FOUR:  r_base[3] <= i_cfg_wdata[fvsc_pkg::BASE_W-1:0];
                    fvsc_pkg::REG_STEP_ONE:   r_step[0] <= i_cfg_wdata;
                    fvsc_pkg::REG_STEP_TWO:   r_step[1] <= i_cfg_wdata;
                    fvsc_pkg::REG_STEP_THREE: r_step[2] <= i_cfg_wdata;
                    fvsc_pkg::REG_STEP_FOUR:  r_step[3] <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_wp    <= r_wp + 1'b1;
                r_voice <= '0;
                if (r_wp == RING_BITS'(RING_DEPTH - 1)) r_wrapped <= 1'b1;
            end
            if (r_state == fvsc_pkg::F_SINE) begin
                r_phase[r_voice] <= r_phase[r_voice] + fvsc_pkg::PHASE_W'(r_step[r_voice]);
            end
            if (o_push) r_voice <= r_voice + 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) r_cur_w <= r_wp;
        if (r_state == fvsc_pkg::F_SINE) begin
            r_sine <= w_sine[r_phase[r_voice][fvsc_pkg::PHASE_W-1 -: SINE_BITS]];
        end
        if (r_state == fvsc_pkg::F_MOD) begin
            r_m <= fvsc_pkg::M_LOW + w_mod_prod[fvsc_pkg::PROD_M_W-1:16];
        end
        if (r_state == fvsc_pkg::F_DLY) begin
            r_d8 <= w_dly_prod[fvsc_pkg::PROD_M_W-1:16];
        end
    end

endmodule

### rtl/fvsc_back.sv
// Back end: reads two ring taps per request, interpolates, weights and sums
// the voices, then rounds and saturates into the output register.
// Depends on fvsc_pkg.
module fvsc_back #(
    parameter int RING_DEPTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_queue_empty,
    input  fvsc_pkg::t_tap_ctl                   i_tap_ctl,
    input  logic [$clog2(RING_DEPTH)-1:0]        i_tap_addr,
    output logic                                 o_pop,
    output logic [$clog2(RING_DEPTH)-1:0]        o_ring_raddr,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_left_rdata,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_right_rdata,
    output logic                                 o_busy,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [fvsc_pkg::SAMPLE_W-1:0] o_left_out,
    output logic signed [fvsc_pkg::SAMPLE_W-1:0] o_right_out
);

    localparam int RING_BITS = $clog2(RING_DEPTH);
    localparam int SW = fvsc_pkg::SAMPLE_W;

    fvsc_pkg::t_back_state r_state, n_state;
    fvsc_pkg::t_tap_ctl    r_ctl;
    logic [RING_BITS-1:0]  r_a;
    logic signed [SW-1:0]  r_xl, r_xr;
    logic signed [fvsc_pkg::MIX_W-1:0]  r_il, r_ir;
    logic signed [fvsc_pkg::PROD_W-1:0] r_wl, r_wr;
    logic signed [fvsc_pkg::ACC_W-1:0]  r_acc_l, r_acc_r;
    logic                   r_out_valid;
    logic signed [SW-1:0]   r_left, r_right;

    logic signed [SW-1:0]   w_yl, w_yr;
    logic signed [9:0]      w_ka, w_kb;
    logic signed [SW+9:0]   w_pla, w_plb, w_pra, w_prb;
    logic signed [fvsc_pkg::WGT_W:0]    w_wgt;
    logic signed [fvsc_pkg::ACC_W-1:0]  w_sum_l, w_sum_r;
    logic                   w_last, w_load;

    function automatic logic signed [SW-1:0] round_sat(
            input logic signed [fvsc_pkg::ACC_W-1:0] acc);
        logic signed [fvsc_pkg::ACC_W-1:0] sh;
        sh = (acc + (fvsc_pkg::ACC_W'(1) <<< 22)) >>> 23;
        if (sh > fvsc_pkg::ACC_W'(signed'(24'sh7FFFFF))) return 24'sh7FFFFF;
        if (sh < fvsc_pkg::ACC_W'(signed'(24'sh800000))) return 24'sh800000;
        return sh[SW-1:0];
    endfunction

    // interpolation and weighting
    assign w_yl    = r_ctl.valid_b ? i_left_rdata  : '0;
    assign w_yr    = r_ctl.valid_b ? i_right_rdata : '0;
    assign w_ka    = $signed({1'b0, 9'(9'd256 - {1'b0, r_ctl.frac})});
    assign w_kb    = $signed({2'b00, r_ctl.frac});
    assign w_pla   = r_xl * w_ka;
    assign w_plb   = w_yl * w_kb;
    assign w_pra   = r_xr * w_ka;
    assign w_prb   = w_yr * w_kb;
    assign w_wgt   = $signed({1'b0, fvsc_pkg::VOICE_WEIGHT[r_ctl.voice]});
    assign w_sum_l = ((r_ctl.voice == '0) ? '0 : r_acc_l) + fvsc_pkg::ACC_W'(r_wl);
    assign w_sum_r = ((r_ctl.voice == '0) ? '0 : r_acc_r) + fvsc_pkg::ACC_W'(r_wr);
    assign w_last  = (r_ctl.voice == fvsc_pkg::LAST_VOICE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fvsc_pkg::B_IDLE:   if (!i_queue_empty) n_state = fvsc_pkg::B_ADDR_B;
            fvsc_pkg::B_ADDR_B: n_state = fvsc_pkg::B_MIX;
            fvsc_pkg::B_MIX:    n_state = fvsc_pkg::B_WEIGHT;
            fvsc_pkg::B_WEIGHT: n_state = fvsc_pkg::B_ACC;
            fvsc_pkg::B_ACC: begin
                if (!w_last || !(r_out_valid && i_out_stall)) n_state = fvsc_pkg::B_IDLE;
            end
            default: n_state = fvsc_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop        = (r_state == fvsc_pkg::B_IDLE) && !i_queue_empty;
        o_ring_raddr = (r_state == fvsc_pkg::B_IDLE) ? i_tap_addr : r_a + 1'b1;
        o_busy       = (r_state != fvsc_pkg::B_IDLE);
        w_load       = (r_state == fvsc_pkg::B_ACC) && w_last
                       && !(r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fvsc_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctl <= i_tap_ctl;
            r_a   <= i_tap_addr;
        end
        if (r_state == fvsc_pkg::B_ADDR_B) begin
            r_xl <= r_ctl.valid_a ? i_left_rdata  : '0;
            r_xr <= r_ctl.valid_a ? i_right_rdata : '0;
        end
        if (r_state == fvsc_pkg::B_MIX) begin
            r_il <= fvsc_pkg::MIX_W'(w_pla + w_plb);
            r_ir <= fvsc_pkg::MIX_W'(w_pra + w_prb);
        end
        if (r_state == fvsc_pkg::B_WEIGHT) begin
            // full product width: both operands extend to the register width
            r_wl <= r_il * w_wgt;
            r_wr <= r_ir * w_wgt;
        end
        if ((r_state == fvsc_pkg::B_ACC) && !w_last) begin
            r_acc_l <= w_sum_l;
            r_acc_r <= w_sum_r;
        end
        if (w_load) begin
            r_left  <= round_sat(w_sum_l);
            r_right <= round_sat(w_sum_r);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left;
    assign o_right_out = r_right;

endmodule

### rtl/fvsc_checker.sv
// Port-level checks for the chorus unit, attached by bind.
// Depends on four_voice_stereo_chorus_unit and fvsc_pkg.
module fvsc_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [fvsc_pkg::SAMPLE_W-1:0] o_left_out,
    input logic signed [fvsc_pkg::SAMPLE_W-1:0] o_right_out
);

    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_left_out)
                                       && $stable(o_right_out))
        else $error("stalled result changed");

    // the front is busy right after it takes a request
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken on consecutive cycles");

    // a fresh request cannot produce an early result
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result appeared too early");

endmodule

bind four_voice_stereo_chorus_unit fvsc_checker u_checker (.*);

### bench/fvsc_chorus_checker.sv
// Checker for the four-voice stereo chorus: watches the sample and mix channels,
// predicts each mix from its own copy of rings, LFO phases and registers.
// Depends on fvsc_pkg for widths and register names.
`timescale 1ns / 100ps

module fvsc_chorus_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fvsc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [fvsc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_left_in,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_right_in,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_left_out,
    input  logic signed [fvsc_pkg::SAMPLE_W-1:0] i_right_out,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_mix_count
);

    localparam int DEPTH   = 4096;
    localparam int ENTRIES = 1024;
    localparam int SW      = fvsc_pkg::SAMPLE_W;
    localparam int NV      = fvsc_pkg::NUM_VOICES;
    localparam longint SPAN = longint'(DEPTH) << 8;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } t_mix;

    logic signed [SW-1:0]                left_hist [DEPTH];
    logic signed [SW-1:0]                right_hist [DEPTH];
    logic signed [fvsc_pkg::SINE_W-1:0]  sine_lut [ENTRIES];
    logic [11:0]                         wr_ptr;
    logic [fvsc_pkg::PHASE_W-1:0]        phase [NV];
    logic [fvsc_pkg::BASE_W-1:0]         base_dly [NV];
    logic [fvsc_pkg::STEP_W-1:0]         lfo_inc [NV];
    t_mix                                mix_queue [$];

    function automatic logic signed [fvsc_pkg::SINE_W-1:0] sine_value(input int k);
        longint unsigned t, quad, r, x, x2, p, s, mag;
        t    = (longint'(k) << 32) / ENTRIES;
        quad = t >> 30;
        r    = t & 64'h3FFF_FFFF;
        if (quad[0]) r = 64'd1073741824 - r;
        x    = (r * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        p    = 64'd1073741824 - x2 / 72;
        p    = 64'd1073741824 - ((x2 * p) >> 30) / 42;
        p    = 64'd1073741824 - ((x2 * p) >> 30) / 20;
        p    = 64'd1073741824 - ((x2 * p) >> 30) / 6;
        s    = (x * p) >> 30;
        mag  = (s * 64'd32767 + 64'd536870912) >> 30;
        if (mag > 64'd32767) mag = 64'd32767;
        return (quad >= 2) ? -fvsc_pkg::SINE_W'(mag) : fvsc_pkg::SINE_W'(mag);
    endfunction

    function automatic logic signed [SW-1:0] round_sat(input longint acc);
        longint v;
        v = (acc + (longint'(1) << 22)) >>> 23;
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return SW'(v);
    endfunction

    // write the sample, read four modulated taps, advance phases and pointer
    task automatic chorus_predict(input logic signed [SW-1:0] l,
                                  input logic signed [SW-1:0] r);
        longint acc_l, acc_r, m, d8, pos, f, wgt;
        int a, b, idx;
        t_mix mix;
        acc_l = 0;
        acc_r = 0;
        left_hist[wr_ptr]  = l;
        right_hist[wr_ptr] = r;
        for (int v = 0; v < NV; v++) begin
            idx = int'((longint'(phase[v]) * ENTRIES) >> 32);
            m   = longint'(fvsc_pkg::M_LOW)
                  + ((longint'(fvsc_pkg::M_SPAN) * (longint'(sine_lut[idx]) + 32768)) >>> 16);
            d8  = (longint'(base_dly[v]) * ((longint'(1) << 24) + m)) >>> 16;
            pos = (longint'(wr_ptr) << 8) + SPAN - (d8 % SPAN);
            if (pos >= SPAN) pos -= SPAN;
            a = int'(pos >> 8);
            f = pos & 255;
            b = (a + 1 >= DEPTH) ? 0 : a + 1;
            wgt = longint'(fvsc_pkg::VOICE_WEIGHT[v]);
            acc_l += wgt * (longint'(left_hist[a]) * (256 - f) + longint'(left_hist[b]) * f);
            acc_r += wgt * (longint'(right_hist[a]) * (256 - f)
                     + longint'(right_hist[b]) * f);
            phase[v] = phase[v] + fvsc_pkg::PHASE_W'(lfo_inc[v]);
        end
        mix.left  = round_sat(acc_l);
        mix.right = round_sat(acc_r);
        mix_queue.push_back(mix);
        wr_ptr = wr_ptr + 12'd1;
    endtask

    task automatic report_mismatch(input string what, input logic [SW-1:0] got,
                                   input logic [SW-1:0] want);
        $display("mismatch %0s at mix %0d: got %0d want %0d", what, o_mix_count,
                 $signed(got), $signed(want));
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_mix_count  = 0;
        o_pending    = 0;
        for (int k = 0; k < ENTRIES; k++) sine_lut[k] = sine_value(k);
    end

    always @(posedge i_clk) begin
        t_mix want;
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                left_hist[k]  = '0;
                right_hist[k] = '0;
            end
            wr_ptr = '0;
            for (int v = 0; v < NV; v++) begin
                phase[v]    = '0;
                base_dly[v] = fvsc_pkg::BASE_RESET[v];
                lfo_inc[v]  = fvsc_pkg::STEP_RESET[v];
            end
            mix_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr <= fvsc_pkg::REG_BASE_FOUR)
                    base_dly[i_cfg_addr] = i_cfg_wdata[fvsc_pkg::BASE_W-1:0];
                else
                    lfo_inc[i_cfg_addr - fvsc_pkg::REG_STEP_ONE] = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) chorus_predict(i_left_in, i_right_in);
            if (i_out_valid && !i_out_stall) begin
                if (mix_queue.size() == 0) begin
                    $display("unexpected mix %0d", o_mix_count);
                    o_fail_count++;
                end else begin
                    want = mix_queue.pop_front();
                    if (i_left_out !== want.left) report_mismatch("left", i_left_out, want.left);
                    if (i_right_out !== want.right)
                        report_mismatch("right", i_right_out, want.right);
                end
                o_mix_count++;
            end
        end
        o_pending = mix_queue.size();
    end
endmodule

### bench/tb_four_voice_stereo_chorus_unit.sv
// Testbench top for the four-voice stereo chorus: clock, reset, register phases,
// sample stimulus and verdict. Depends on fvsc_pkg, the unit and fvsc_chorus_checker.
`timescale 1ns / 100ps

module tb_four_voice_stereo_chorus_unit;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  SW = fvsc_pkg::SAMPLE_W;
    localparam int  DW = fvsc_pkg::CFG_DATA_W;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic [fvsc_pkg::CFG_ADDR_W-1:0]     cfg_addr;
    logic [DW-1:0]                       cfg_wdata;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [SW-1:0]                left_in;
    logic signed [SW-1:0]                right_in;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [SW-1:0]                left_out;
    logic signed [SW-1:0]                right_out;
    int                                  fail_count;
    int                                  pending;
    int                                  mix_count;
    int                                  cycle_count;
    int                                  sent_count;
    // idle percentages for each side; zero during the calm stretch
    int                                  send_idle_pct;
    int                                  recv_idle_pct;
    // long receiver hold-off, counted down in the receiver's process
    int                                  hold_cycles;

    four_voice_stereo_chorus_unit dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_left_in(left_in), .i_right_in(right_in),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_left_out(left_out), .o_right_out(right_out)
    );

    fvsc_chorus_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_left_in(left_in), .i_right_in(right_in),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_left_out(left_out), .i_right_out(right_out),
        .o_fail_count(fail_count), .o_pending(pending), .o_mix_count(mix_count)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop if the unit hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[four_voice_stereo_chorus_unit] ERROR");
            $finish;
        end
    end

    // receiver: stall at random, or hold off for a stretch when asked
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // write one register between phases, while the unit is idle
    task automatic write_reg(input fvsc_pkg::t_cfg_index idx, input logic [DW-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // offer one request, keep it steady until the unit takes it; valid stays
    // up afterwards so back-to-back requests need no gap
    task automatic send_sample(input logic signed [SW-1:0] l,
                               input logic signed [SW-1:0] r);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    // drop valid, wait until every mix is back, then let the unit settle
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // half full-range random samples, a quarter small, a quarter at the rails to hit saturation
    task automatic send_random(input int count);
        logic signed [SW-1:0] l, r;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(3, 0))
                0: begin
                    l = $urandom_range(1, 0) ? 24'sh7FFFFF : 24'sh800000;
                    r = $urandom_range(1, 0) ? 24'sh7FFFFF : 24'sh800000;
                end
                1: begin
                    l = SW'($signed($urandom_range(2000, 0)) - 1000);
                    r = SW'($signed($urandom_range(2000, 0)) - 1000);
                end
                default: begin
                    l = SW'($urandom);
                    r = SW'($urandom);
                end
            endcase
            send_sample(l, r);
        end
    endtask

    initial begin
        cycle_count   = 0;
        sent_count    = 0;
        hold_cycles   = 0;
        send_idle_pct = 33;
        recv_idle_pct = 33;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = fvsc_pkg::REG_BASE_ONE;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        left_in   = '0;
        right_in  = '0;
        out_stall = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, rails, zero, single impulses
        send_sample(24'sh7FFFFF, 24'sh800000);
        send_sample(24'sh800000, 24'sh7FFFFF);
        send_sample(24'sh000000, 24'sh000000);
        send_sample(24'shFFFFFF, 24'sh000001);
        send_sample(24'sh555555, 24'shAAAAAA);
        drain();

        // zero delay reads the current sample; max, zero, half and unit steps; neighbor tap wraps
        write_reg(fvsc_pkg::REG_BASE_ONE, 24'd0);
        write_reg(fvsc_pkg::REG_BASE_TWO, 24'd1);
        write_reg(fvsc_pkg::REG_BASE_THREE, 24'd4095);
        write_reg(fvsc_pkg::REG_BASE_FOUR, 24'd3700);
        write_reg(fvsc_pkg::REG_STEP_ONE, 24'hFFFFFF);
        write_reg(fvsc_pkg::REG_STEP_TWO, 24'd0);
        write_reg(fvsc_pkg::REG_STEP_THREE, 24'h800000);
        write_reg(fvsc_pkg::REG_STEP_FOUR, 24'd1);
        for (int n = 0; n < 10; n++)
            send_sample(n[0] ? 24'sh7FFFFF : 24'sh800000, 24'sh123456);
        drain();

        // random phase with one long receiver hold-off so the unit backs up
        fork
            send_random(300);
            begin
                repeat (200) @(negedge clk);
                hold_cycles = 600;
            end
        join
        drain();

        // calm stretch with random registers
        for (int v = 0; v < fvsc_pkg::NUM_VOICES; v++) begin
            write_reg(fvsc_pkg::t_cfg_index'(fvsc_pkg::REG_BASE_ONE + v),
                      DW'($urandom_range(4095, 0)));
            write_reg(fvsc_pkg::t_cfg_index'(fvsc_pkg::REG_STEP_ONE + v), DW'($urandom));
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(300);
        drain();

        // small delays and small steps, then back to random idling
        send_idle_pct = 33;
        recv_idle_pct = 33;
        for (int v = 0; v < fvsc_pkg::NUM_VOICES; v++) begin
            write_reg(fvsc_pkg::t_cfg_index'(fvsc_pkg::REG_BASE_ONE + v),
                      DW'($urandom_range(8, 1)));
            write_reg(fvsc_pkg::t_cfg_index'(fvsc_pkg::REG_STEP_ONE + v),
                      DW'($urandom_range(70000, 0)));
        end
        send_random(480);
        drain();

        $display("sent %0d stereo samples, checked %0d mixes over four register settings",
                 sent_count, mix_count);
        $display("with one long output hold-off and one stretch without idling");
        if (fail_count == 0) begin
            $display("[four_voice_stereo_chorus_unit] OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[four_voice_stereo_chorus_unit] ERROR");
        end
        $finish;
    end
endmodule

### files.f
rtl/fvsc_pkg.sv
rtl/fvsc_ram.sv
rtl/fvsc_queue.sv
rtl/fvsc_front.sv
rtl/fvsc_back.sv
rtl/four_voice_stereo_chorus_unit.sv
rtl/fvsc_checker.sv
bench/fvsc_chorus_checker.sv
bench/tb_four_voice_stereo_chorus_unit.sv
